// ===== rtl/core/bitmap_range_engine_top_defines.svh =====
// ----------------------------------------------------------------------------
// bitmap_range_engine_top_defines.svh
// Assertion macros used by the bitmap range engine RTL.
// ----------------------------------------------------------------------------
`ifndef BITMAP_RANGE_ENGINE_TOP_DEFINES_SVH
`define BITMAP_RANGE_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bre_pkg.sv =====
// ----------------------------------------------------------------------------
// bre_pkg
// Types and constants for the bitmap range engine.
// ----------------------------------------------------------------------------
package bre_pkg;

    // Default geometry of the bitmap.
    localparam int BITMAP_BITS_DEF = 4096;
    localparam int WORD_BITS_DEF   = 32;

    // Fixed field widths of the request word.
    localparam int OFFSET_W = 12;
    localparam int COUNT_W  = 13;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_TEST  = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_FLIP  = 2'd3
    } t_op;

    // Request word.
    typedef struct packed {
        t_op                 op;
        logic [OFFSET_W-1:0] bit_offset;
        logic [COUNT_W-1:0]  bit_count;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic any_set;
        logic range_error;
    } t_out_word;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/core/bre_ram.sv =====
// ----------------------------------------------------------------------------
// bre_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/bitmap_range_engine_top.sv =====
// Sequence: a range request walks its words from first to last in ST_WALK; ST_DONE
// then loads the result register once the output slot is free. A zero count or an
// out-of-range request goes straight to ST_DONE. Throughput: one word read-modify-write
// per cycle through the bitmap RAM while walking; no new request is taken until
// the last result is loaded. Reset: synchronous active low; afterwards a clearing
// pass writes zero to every word, one per cycle, before requests are taken.
// ----------------------------------------------------------------------------
// bitmap_range_engine_top
// Bitmap store with range test, set, clear and flip operations, walked one
// RAM word at a time with edge masks on partial first and last words.
// ----------------------------------------------------------------------------
`include "bitmap_range_engine_top_defines.svh"

module bitmap_range_engine_top
    import bre_pkg::*;
#(
    // WORD_BITS must be a power of two.
    parameter int BITMAP_BITS = BITMAP_BITS_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int WORD_COUNT = (BITMAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int IDX_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int OFS_W      = $clog2(WORD_BITS);
    localparam int HI_W       = ($clog2(BITMAP_BITS + 1) > COUNT_W + 1)
                                ? $clog2(BITMAP_BITS + 1) : COUNT_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORD_COUNT - 1);

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_clr_addr;
    logic [IDX_W-1:0]       r_rd_addr;
    logic [IDX_W-1:0]       r_wr_addr;
    logic [IDX_W-1:0]       r_first;
    logic [IDX_W-1:0]       r_last;
    logic [OFS_W-1:0]       r_lo_ofs;
    logic [OFS_W-1:0]       r_hi_ofs;
    t_op                    r_op;
    logic                   r_rd_more;
    logic                   r_pend;
    logic                   r_found;
    logic                   r_res_err;
    logic                   r_out_valid;
    t_out_word              r_out_word;

    logic                   in_fire;
    logic                   slot_free;
    logic [HI_W-1:0]        hi_ext;
    logic [HI_W-1:0]        hi_m1;
    logic                   req_err;
    logic                   req_empty;
    logic [IDX_W-1:0]       req_first;
    logic [IDX_W-1:0]       req_last;

    logic [OFS_W-1:0]       s_ofs;
    logic [OFS_W-1:0]       e_ofs;
    logic [WORD_BITS-1:0]   word_mask;
    logic [WORD_BITS-1:0]   rd_data;
    logic [WORD_BITS-1:0]   mod_data;
    logic                   hit;

    logic                   ram_wr_en;
    logic [IDX_W-1:0]       ram_wr_addr;
    logic [WORD_BITS-1:0]   ram_wr_data;
    logic                   ram_rd_en;
    logic [IDX_W-1:0]       ram_rd_addr;

    // Handshake qualifiers.
    assign in_fire   = i_in_valid && o_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;

    // Request decode: range end, error check and first and last word.
    always_comb begin
        hi_ext    = HI_W'(i_in_word.bit_offset) + HI_W'(i_in_word.bit_count);
        hi_m1     = hi_ext - HI_W'(1);
        req_err   = hi_ext > HI_W'(BITMAP_BITS);
        req_empty = (i_in_word.bit_count == '0);
        req_first = IDX_W'(i_in_word.bit_offset >> OFS_W);
        req_last  = IDX_W'(hi_m1 >> OFS_W);
    end

    // Edge masks for the word whose read data has arrived, and its update.
    always_comb begin
        s_ofs     = (r_wr_addr == r_first) ? r_lo_ofs : '0;
        e_ofs     = (r_wr_addr == r_last) ? r_hi_ofs : '1;
        word_mask = ({WORD_BITS{1'b1}} << s_ofs) & ({WORD_BITS{1'b1}} >> (~e_ofs));
        hit       = (r_op == OP_TEST) && ((rd_data & word_mask) != '0);
        case (r_op)
            OP_SET:   mod_data = rd_data | word_mask;
            OP_CLEAR: mod_data = rd_data & ~word_mask;
            OP_FLIP:  mod_data = rd_data ^ word_mask;
            default:  mod_data = rd_data;
        endcase
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = (req_err || req_empty) ? ST_DONE : ST_WALK;
                end
            end
            ST_WALK: begin
                if (r_pend && !r_rd_more) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State-dependent outputs: input ready and RAM port controls.
    always_comb begin
        o_in_ready  = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_wr_addr;
        ram_wr_data = mod_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_rd_addr;
        case (r_state)
            ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr_addr;
                ram_wr_data = '0;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_WALK: begin
                ram_rd_en = r_rd_more;
                ram_wr_en = r_pend && (r_op != OP_TEST);
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_rd_more   <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (in_fire) begin
                r_rd_more <= !(req_err || req_empty);
                r_pend    <= 1'b0;
            end else if (r_state == ST_WALK) begin
                r_rd_more <= r_rd_more && (r_rd_addr != r_last);
                r_pend    <= r_rd_more;
            end
            if (r_state == ST_DONE && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and walk payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op      <= i_in_word.op;
            r_first   <= req_first;
            r_last    <= req_last;
            r_lo_ofs  <= i_in_word.bit_offset[OFS_W-1:0];
            r_hi_ofs  <= hi_m1[OFS_W-1:0];
            r_rd_addr <= req_first;
            r_found   <= 1'b0;
            r_res_err <= req_err;
        end else if (r_state == ST_WALK) begin
            if (r_rd_more) begin
                r_rd_addr <= r_rd_addr + IDX_W'(1);
                r_wr_addr <= r_rd_addr;
            end
            if (r_pend && hit) begin
                r_found <= 1'b1;
            end
        end
        if (r_state == ST_DONE && slot_free) begin
            r_out_word.any_set     <= r_found;
            r_out_word.range_error <= r_res_err;
        end
    end

    // Bitmap word store.
    bre_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_bre_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Checks on the read-modify-write pipeline and the result word.
    `BRE_ASSERT_IMP(a_no_rw_collision, i_clk, i_rst_n, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr, "bitmap read and write hit the same word")
    `BRE_ASSERT_IMP(a_wr_in_range, i_clk, i_rst_n, r_state == ST_WALK && r_pend, r_wr_addr >= r_first && r_wr_addr <= r_last, "bitmap write outside the requested range")
    `BRE_ASSERT_IMP(a_err_not_set, i_clk, i_rst_n, o_out_valid, !(o_out_word.any_set && o_out_word.range_error), "range error reported together with a set bit")
    `BRE_ASSERT_NEXT(a_done_loads, i_clk, i_rst_n, r_state == ST_DONE && slot_free, o_out_valid && r_state == ST_IDLE, "finished request did not reach the output register")

endmodule
